// ===== src/object_range_chunk_splitter_unit_assert.svh =====
// Assertion macros for the object range chunk splitter.
// Included by the top level; relies on signals named clk and rst in the including module.
`ifndef OBJECT_RANGE_CHUNK_SPLITTER_UNIT_ASSERT_SVH
`define OBJECT_RANGE_CHUNK_SPLITTER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define ORCS_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("orcs: same-cycle check failed");

`define ORCS_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("orcs: next-cycle check failed");

`else

`define ORCS_ASSERT_IMP(label, a, c)

`define ORCS_ASSERT_NEXT(label, a, c)

`endif

`endif

// ===== src/orcs_pkg.sv =====
// Package for the object range chunk splitter: fixed geometry, status codes,
// register indexes, microcode word type and the microprogram ROM. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package orcs_pkg;

  localparam int OBJ_LOG2   = 7;
  localparam int CHUNK_LOG2 = 19;
  localparam int LG_MIN     = 12;
  localparam int LG_MAX     = 24;
  localparam int IN_BLK_W   = LG_MAX - OBJ_LOG2;
  localparam int CNT_W      = CHUNK_LOG2 - OBJ_LOG2 + 1;
  localparam int BLKNUM_W   = 31;
  localparam int OFF_W      = 24;
  localparam int LEN_W      = 20;
  localparam int TDATA_W    = BLKNUM_W + OFF_W + LEN_W + 32 + CNT_W;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  localparam logic REG_BLOCK_SIZE_LOG2 = 1'b0;
  localparam logic REG_TOTAL_OBJECTS   = 1'b1;

  localparam logic [2:0] UPC_FETCH = 3'd0;
  localparam logic [2:0] UPC_RANGE = 3'd1;
  localparam logic [2:0] UPC_ZERO  = 3'd2;
  localparam logic [2:0] UPC_CALC  = 3'd3;
  localparam logic [2:0] UPC_EMIT  = 3'd4;
  localparam logic [2:0] UPC_ERR   = 3'd5;
  localparam logic [2:0] UPC_LOOP  = 3'd6;
  localparam logic [2:0] UPC_SPARE = 3'd7;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_INPUT,
    C_RANGE_BAD,
    C_ZERO,
    C_OUT_BUSY,
    C_DONE
  } cond_t;

  typedef struct packed {
    logic       take_in;
    logic       calc;
    logic       emit;
    logic       err;
    cond_t      cond;
    logic [2:0] jump_to;
    logic [2:0] next_to;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [2:0] upc);
    ucode_t w;
    w = '{take_in: 1'b0, calc: 1'b0, emit: 1'b0, err: 1'b0, cond: C_NEVER,
          jump_to: UPC_FETCH, next_to: UPC_FETCH};
    unique case (upc)
      UPC_FETCH: begin
        w.take_in = 1'b1;
        w.cond    = C_NO_INPUT;
        w.jump_to = UPC_FETCH;
        w.next_to = UPC_RANGE;
      end
      UPC_RANGE: begin
        w.cond    = C_RANGE_BAD;
        w.jump_to = UPC_ERR;
        w.next_to = UPC_ZERO;
      end
      UPC_ZERO: begin
        w.cond    = C_ZERO;
        w.jump_to = UPC_FETCH;
        w.next_to = UPC_CALC;
      end
      UPC_CALC: begin
        w.calc    = 1'b1;
        w.next_to = UPC_EMIT;
      end
      UPC_EMIT: begin
        w.emit    = 1'b1;
        w.cond    = C_OUT_BUSY;
        w.jump_to = UPC_EMIT;
        w.next_to = UPC_LOOP;
      end
      UPC_ERR: begin
        w.err     = 1'b1;
        w.cond    = C_OUT_BUSY;
        w.jump_to = UPC_ERR;
        w.next_to = UPC_FETCH;
      end
      UPC_LOOP: begin
        w.cond    = C_DONE;
        w.jump_to = UPC_FETCH;
        w.next_to = UPC_CALC;
      end
      UPC_SPARE: begin
        w.next_to = UPC_FETCH;
      end
      default: begin
        w.next_to = UPC_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/object_range_chunk_splitter_unit.sv =====
// Object range chunk splitter: a microcoded sequencer with its datapath and APB registers.
// Depends on orcs_pkg and on object_range_chunk_splitter_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// Each request takes a range of 128-byte objects and splits it into chunks that never cross a
// storage block and never exceed min(block size, 512 KiB); one result per chunk, the final one
// marked by tlast. A range ending beyond total_objects gives a single error result, a zero count
// gives none, and after MAX_CHUNKS chunks the rest is dropped with a truncated status. A request
// runs the fetch, range and zero steps (a bad range goes to the error step), then the three-step
// chunk loop of the microprogram (compute, emit, branch) per chunk; emit and error steps wait
// while m_tready low holds the output register. Only one request is worked on at a time; the
// next is accepted once the last result has been loaded into the output register.
module object_range_chunk_splitter_unit #(
  parameter int MAX_CHUNKS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // first_index [31:0], count [63:32]
  input  wire logic [63:0]                 s_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // block_number [30:0], byte_offset [54:31], byte_length [74:55], chunk_first [106:75],
  // chunk_count [119:107]
  output logic [orcs_pkg::TDATA_W-1:0]     m_tdata,
  // status [1:0]
  output logic [1:0]                       m_tuser,
  output logic                             m_tlast,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import orcs_pkg::*;

  `include "object_range_chunk_splitter_unit_assert.svh"

  localparam int KW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

  logic [4:0]          block_size_log2;
  logic [31:0]         total_objects;

  logic [2:0]          upc;
  ucode_t              uw;
  logic                cond_true;

  logic [31:0]         obj;
  logic [31:0]         rem;
  logic [KW-1:0]       k;
  logic                done;
  logic [CNT_W-1:0]    n_r;
  logic [BLKNUM_W-1:0] blk_r;
  logic [OFF_W-1:0]    off_r;

  logic [4:0]          lg;
  logic [4:0]          lg_chunk;
  logic [4:0]          sh;
  logic [4:0]          cs;
  logic [IN_BLK_W:0]   per_block;
  logic [IN_BLK_W-1:0] in_blk;
  logic [IN_BLK_W:0]   room;
  logic [CNT_W-1:0]    per_chunk;
  logic [31:0]         n_a;
  logic [31:0]         n_b;
  logic [32:0]         range_end;
  logic                range_bad;
  logic [31:0]         rem_after;
  logic                at_end;
  logic                at_limit;
  logic                out_busy;
  logic                cfg_wr;

  logic [BLKNUM_W-1:0] o_blk;
  logic [OFF_W-1:0]    o_off;
  logic [LEN_W-1:0]    o_len;
  logic [31:0]         o_first;
  logic [CNT_W-1:0]    o_cnt;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size_log2 <= 5'd22;
      total_objects   <= 32'd0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BLOCK_SIZE_LOG2: block_size_log2 <= pwdata[4:0];
        REG_TOTAL_OBJECTS:   total_objects   <= pwdata;
        default:             total_objects   <= total_objects;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BLOCK_SIZE_LOG2: prdata = {27'd0, block_size_log2};
      REG_TOTAL_OBJECTS:   prdata = total_objects;
      default:             prdata = 32'd0;
    endcase
  end

  assign uw       = ucode_rom(upc);
  assign out_busy = m_tvalid && !m_tready;
  assign s_tready = uw.take_in;

  assign range_end = {1'b0, obj} + {1'b0, rem};
  assign range_bad = range_end > {1'b0, total_objects};

  always_comb begin
    unique case (uw.cond)
      C_NEVER:     cond_true = 1'b0;
      C_NO_INPUT:  cond_true = !s_tvalid;
      C_RANGE_BAD: cond_true = range_bad;
      C_ZERO:      cond_true = (rem == 32'd0);
      C_OUT_BUSY:  cond_true = out_busy;
      C_DONE:      cond_true = done;
      default:     cond_true = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_FETCH;
    end else begin
      upc <= cond_true ? uw.jump_to : uw.next_to;
    end
  end

  always_comb begin
    if (block_size_log2 < 5'(LG_MIN)) begin
      lg = 5'(LG_MIN);
    end else if (block_size_log2 > 5'(LG_MAX)) begin
      lg = 5'(LG_MAX);
    end else begin
      lg = block_size_log2;
    end
    lg_chunk  = (lg > 5'(CHUNK_LOG2)) ? 5'(CHUNK_LOG2) : lg;
    sh        = lg - 5'(OBJ_LOG2);
    cs        = lg_chunk - 5'(OBJ_LOG2);
    per_block = (IN_BLK_W + 1)'(1) << sh;
    in_blk    = obj[IN_BLK_W-1:0] & per_block[IN_BLK_W-1:0] - IN_BLK_W'(1);
    room      = per_block - {1'b0, in_blk};
    per_chunk = CNT_W'(1) << cs;
    n_a       = (rem < 32'(per_chunk)) ? rem : 32'(per_chunk);
    n_b       = (n_a < 32'(room)) ? n_a : 32'(room);
  end

  assign rem_after = rem - 32'(n_r);
  assign at_end    = (rem_after == 32'd0);
  assign at_limit  = (k == KW'(MAX_CHUNKS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      obj  <= 32'd0;
      rem  <= 32'd0;
      k    <= '0;
      done <= 1'b0;
    end else if (uw.take_in && s_tvalid) begin
      obj  <= s_tdata[31:0];
      rem  <= s_tdata[63:32];
      k    <= '0;
      done <= 1'b0;
    end else if (uw.emit && !out_busy) begin
      obj  <= obj + 32'(n_r);
      rem  <= rem_after;
      k    <= k + KW'(1);
      done <= at_end || at_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.calc) begin
      n_r   <= n_b[CNT_W-1:0];
      blk_r <= BLKNUM_W'(obj >> sh);
      off_r <= {in_blk, OBJ_LOG2'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((uw.emit || uw.err) && !out_busy) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.err && !out_busy) begin
      o_blk   <= '0;
      o_off   <= '0;
      o_len   <= '0;
      o_first <= '0;
      o_cnt   <= '0;
      m_tuser <= ST_RANGE;
      m_tlast <= 1'b1;
    end else if (uw.emit && !out_busy) begin
      o_blk   <= blk_r;
      o_off   <= off_r;
      o_len   <= {n_r, OBJ_LOG2'(0)};
      o_first <= obj;
      o_cnt   <= n_r;
      m_tuser <= (!at_end && at_limit) ? ST_TRUNC : ST_OK;
      m_tlast <= at_end || at_limit;
    end
  end

  assign m_tdata = {o_cnt, o_first, o_len, o_off, o_blk};

  `ORCS_ASSERT_IMP(a_error_is_last, m_tvalid && m_tuser == ST_RANGE, m_tlast)
  `ORCS_ASSERT_IMP(a_trunc_is_last, m_tvalid && m_tuser == ST_TRUNC, m_tlast)
  `ORCS_ASSERT_IMP(a_length_matches_count, m_tvalid, o_len == (LEN_W'(o_cnt) << OBJ_LOG2))
  `ORCS_ASSERT_NEXT(a_accept_goes_to_check, s_tvalid && s_tready, upc == UPC_RANGE)

endmodule

`default_nettype wire
